[design/tvs_pkg.sv]
// Shared types and constants for the trilinear volume sampler.
package tvs_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_RES_DEF = 16;
	localparam int COORD_FRAC_BITS_DEF = 16;

	// Fixed field widths.
	localparam int CFG_W = 5;
	localparam int CH_W = 8;
	localparam int OUT_W = 16;
	localparam int WGT_W = 17;
	localparam int VOX_W = 3 * CH_W;

	// Queue depths: input queue and result queue.
	localparam int IQ_DEPTH = 2;
	localparam int OQ_DEPTH = 8;

	// Request kind carried on tuser.
	typedef enum logic {
		REQ_WRITE  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_type_t;

	// Classification made by the front end for each queued item.
	typedef struct packed {
		logic       is_sample;
		logic       wr_ok;
		logic [2:0] clamp;
	} cls_t;

endpackage

[design/tvs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tvs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/tvs_fifo.sv]
// Small register-based first-in first-out queue.
module tvs_fifo #(
	parameter int W = 8,
	parameter int DEPTH = 2,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

[design/tvs_front.sv]
// Front end: accepts requests, classifies them and queues them for the back end.
module tvs_front import tvs_pkg::*; #(
	parameter int MAX_RES = MAX_RES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int IDW = 88
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [IDW-1:0] in_data,
	input  logic           in_user,
	output logic           q_valid,
	input  logic           q_pop,
	output logic [IDW-1:0] q_data,
	output cls_t           q_cls
);

	localparam int CW = $clog2(MAX_RES);
	localparam int CF = COORD_FRAC_BITS;
	localparam int CCW = CF + 1;
	localparam int SX_LO = 3 * CW + VOX_W;
	localparam int QW = IDW + $bits(cls_t);

	cls_t cls;
	logic [CCW-1:0] crd [3];
	logic full, empty;
	logic [QW-1:0] q_word;

	// Classify: request kind, write range check, coordinate clamp flags.
	always_comb begin
		cls.is_sample = (req_type_t'(in_user) == REQ_SAMPLE);
		cls.wr_ok = (int'(in_data[CW-1:0]) < MAX_RES) &&
			(int'(in_data[2*CW-1:CW]) < MAX_RES) &&
			(int'(in_data[3*CW-1:2*CW]) < MAX_RES);
		for (int a = 0; a < 3; a++) begin
			crd[a] = in_data[SX_LO + a*CCW +: CCW];
			cls.clamp[a] = crd[a][CF] && (|crd[a][CF-1:0]);
		end
	end

	tvs_fifo #(
		.W(QW),
		.DEPTH(IQ_DEPTH)
	) u_iq (
		.clk(clk),
		.arst_n(arst_n),
		.push(in_valid),
		.din({cls, in_data}),
		.full(full),
		.pop(q_pop),
		.dout(q_word),
		.empty(empty)
	);

	assign in_ready = !full;
	assign q_valid = !empty;
	assign q_data = q_word[IDW-1:0];
	assign q_cls = cls_t'(q_word[QW-1:IDW]);

endmodule

[design/tvs_back.sv]
// Back end: index split, banked voxel fetch and three-stage trilinear blend.
module tvs_back import tvs_pkg::*; #(
	parameter int MAX_RES = MAX_RES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int IDW = 88
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  logic [IDW-1:0]   q_data,
	input  cls_t             q_cls,
	output logic             q_pop,
	input  logic             issue_ok,
	output logic             issue_sample,
	input  logic [CFG_W-1:0] resolution,
	output logic             res_valid,
	output logic [3*OUT_W-1:0] res_data
);

	localparam int CW = $clog2(MAX_RES);
	localparam int HW = (CW > 1) ? CW - 1 : 1;
	localparam int BDEPTH = 2 ** (3 * HW);
	localparam int BAW = 3 * HW;
	localparam int CF = COORD_FRAC_BITS;
	localparam int CCW = CF + 1;
	localparam int SX_LO = 3 * CW + VOX_W;
	localparam int PW = CCW + CW;
	localparam logic [WGT_W-1:0] W_ONE = WGT_W'(65536);

	// Issue stage signals.
	logic [CW-1:0] nm1;
	logic zero_n;
	logic [CCW-1:0] crd [3];
	logic [PW-1:0] prod [3];
	logic [CF+15:0] fext [3];
	logic [CW-1:0] idx [3];
	logic [15:0] tf [3];
	logic [VOX_W-1:0] wvox;
	logic do_write;

	// Stage registers.
	logic v_s1, wr_s1, zero_s1;
	logic [CW-1:0] idx_s1 [3];
	logic [15:0] t_s1 [3];
	logic [VOX_W-1:0] wdat_s1;
	logic v_s2, zero_s2;
	logic [2:0] par_s2;
	logic [15:0] t_s2 [3];
	logic v_s3, zero_s3;
	logic [24:0] lx_s3 [3][4];
	logic [15:0] ty_s3, tz_s3;
	logic v_s4, zero_s4;
	logic [40:0] ly_s4 [3][2];
	logic [15:0] tz_s4;
	logic v_s5, zero_s5;
	logic [41:0] hi_s5 [3];
	logic [33:0] lo_s5 [3];

	// Bank signals and blend logic.
	logic [BAW-1:0] baddr [8];
	logic bwe [8];
	logic [VOX_W-1:0] brd [8];
	logic [24:0] lx [3][4];
	logic [40:0] ly [3][2];
	logic [41:0] hi [3];
	logic [33:0] lo [3];
	logic [57:0] vsum [3];

	// Issue: writes always go, samples only when the result queue has room.
	assign q_pop = q_valid && (!q_cls.is_sample || issue_ok);
	assign issue_sample = q_pop && q_cls.is_sample;
	assign do_write = q_pop && !q_cls.is_sample && q_cls.wr_ok;

	// Effective resolution, scaled coordinates, lower index and 16-bit fraction.
	always_comb begin
		zero_n = (resolution < CFG_W'(2));
		if (int'(resolution) > MAX_RES) begin
			nm1 = CW'(MAX_RES - 1);
		end else begin
			nm1 = CW'(int'(resolution) - 1);
		end
		// Stored word keeps red in the top byte and blue in the bottom byte.
		wvox = {q_data[3*CW +: CH_W], q_data[3*CW+CH_W +: CH_W],
			q_data[3*CW+2*CH_W +: CH_W]};
		for (int a = 0; a < 3; a++) begin
			crd[a] = q_cls.clamp[a] ? CCW'(1 << CF) : q_data[SX_LO + a*CCW +: CCW];
			prod[a] = PW'(crd[a]) * PW'(nm1);
			fext[a] = {prod[a][CF-1:0], 16'b0};
			tf[a] = fext[a][CF+15:CF];
			idx[a] = q_cls.is_sample ? prod[a][CF +: CW] : q_data[a*CW +: CW];
		end
	end

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			wr_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue_sample;
			wr_s1 <= do_write;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Each bank holds one parity class; the upper neighbor is always lower plus one.
	// When the upper index would be clamped its weight is zero, and the blend drops
	// those terms so that a voxel outside the volume in use never reaches the result.
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			logic [CW-1:0] ia [3];
			logic [HW-1:0] hf [3];
			for (int a = 0; a < 3; a++) begin
				ia[a] = (idx_s1[a][0] == b[a]) ? idx_s1[a] : idx_s1[a] + 1'b1;
				hf[a] = HW'(ia[a] >> 1);
			end
			baddr[b] = {hf[2], hf[1], hf[0]};
			bwe[b] = wr_s1 && (3'(b) == {idx_s1[2][0], idx_s1[1][0], idx_s1[0][0]});
		end
	end

	for (genvar g = 0; g < 8; g++) begin : g_bank
		tvs_ram #(
			.WIDTH(VOX_W),
			.DEPTH(BDEPTH)
		) u_ram (
			.clk(clk),
			.we(bwe[g]),
			.waddr(baddr[g]),
			.wdata(wdat_s1),
			.raddr(baddr[g]),
			.rdata(brd[g])
		);
	end

	// Blend along x: corner pairs picked from banks by the lower index parity.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int j = 0; j < 4; j++) begin
				logic [CH_W-1:0] ba, bb;
				ba = brd[3'(2*j) ^ par_s2][VOX_W-1-CH_W*c -: CH_W];
				bb = brd[3'(2*j+1) ^ par_s2][VOX_W-1-CH_W*c -: CH_W];
				lx[c][j] = 25'(ba) * 25'(W_ONE - WGT_W'(t_s2[0])) +
					((t_s2[0] == '0) ? 25'(0) : 25'(bb) * 25'(t_s2[0]));
			end
		end
	end

	// Blend along y.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 2; k++) begin
				ly[c][k] = 41'(lx_s3[c][2*k]) * 41'(W_ONE - WGT_W'(ty_s3)) +
					((ty_s3 == '0) ? 41'(0) : 41'(lx_s3[c][2*k+1]) * 41'(ty_s3));
			end
		end
	end

	// Blend along z, split into upper and lower halves of the y results.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			hi[c] = 42'(ly_s4[c][0][40:16]) * 42'(W_ONE - WGT_W'(tz_s4)) +
				((tz_s4 == '0) ? 42'(0) : 42'(ly_s4[c][1][40:16]) * 42'(tz_s4));
			lo[c] = 34'(ly_s4[c][0][15:0]) * 34'(W_ONE - WGT_W'(tz_s4)) +
				((tz_s4 == '0) ? 34'(0) : 34'(ly_s4[c][1][15:0]) * 34'(tz_s4));
		end
	end

	// Recombine and keep byte scale times 256.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			vsum[c] = {hi_s5[c], 16'b0} + 58'(lo_s5[c]);
			res_data[c*OUT_W +: OUT_W] = zero_s5 ? '0 : vsum[c][55:40];
		end
	end
	assign res_valid = v_s5;

	// Data pipeline.
	always_ff @(posedge clk) begin
		zero_s1 <= zero_n;
		wdat_s1 <= wvox;
		for (int a = 0; a < 3; a++) begin
			idx_s1[a] <= idx[a];
			t_s1[a] <= tf[a];
		end
		zero_s2 <= zero_s1;
		par_s2 <= {idx_s1[2][0], idx_s1[1][0], idx_s1[0][0]};
		t_s2 <= t_s1;
		zero_s3 <= zero_s2;
		lx_s3 <= lx;
		ty_s3 <= t_s2[1];
		tz_s3 <= t_s2[2];
		zero_s4 <= zero_s3;
		ly_s4 <= ly;
		tz_s4 <= tz_s3;
		zero_s5 <= zero_s4;
		hi_s5 <= hi;
		lo_s5 <= lo;
	end

endmodule

[design/trilinear_volume_sampler.sv]
// Top level of the trilinear volume sampler.
//
// The slave stream carries requests: tuser selects a voxel write or a sample.
// A write stores one RGB voxel if in range and gives no result; a sample gives
// one result of three 16-bit channels on the master stream, in request order.
// The volume sits in eight RAM banks split by index parity, so all eight
// corners of a sample are read in the same cycle.
// Throughput is one request per cycle while samples find room in the result queue.
// A sample goes through the input queue, index split, bank read, and three blend
// stages, and its result then waits in the result queue. The resolution register
// is to be written with cfg_we only while the block is idle; the block has no check, the user must keep to it.
// Reset clears the queues, the pipeline and the resolution; the voxel store
// holds no defined content until written.
// When the receiver stalls, results collect in an eight-entry queue; samples
// stop issuing once it would be full, and the input queue then fills and
// drops s_axis_tready. Writes keep flowing as long as they are not behind a
// held sample.
module trilinear_volume_sampler import tvs_pkg::*; #(
	parameter int MAX_RES = MAX_RES_DEF,
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	localparam int CW = $clog2(MAX_RES),
	localparam int RAW_W = 3 * CW + VOX_W + 3 * (COORD_FRAC_BITS + 1),
	localparam int IDW = ((RAW_W + 7) / 8) * 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// voxel_x, voxel_y, voxel_z, voxel_red, voxel_green, voxel_blue,
	// sample_x, sample_y, sample_z, zero fill
	input  logic [IDW-1:0]     s_axis_tdata,
	// req_type
	input  logic               s_axis_tuser,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// out_red, out_green, out_blue
	output logic [3*OUT_W-1:0] m_axis_tdata
);

	localparam int OCW = $clog2(OQ_DEPTH + 1);

	logic [CFG_W-1:0] resolution_q;
	logic [OCW-1:0] occ_q;
	logic q_valid, q_pop, issue_ok, issue_sample;
	logic [IDW-1:0] q_data;
	cls_t q_cls;
	logic res_valid;
	logic [3*OUT_W-1:0] res_data;
	logic oq_full, oq_empty, out_xfer;

	// Resolution register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resolution_q <= '0;
		end else if (cfg_we) begin
			resolution_q <= cfg_wdata;
		end
	end

	tvs_front #(
		.MAX_RES(MAX_RES),
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.IDW(IDW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_data(s_axis_tdata),
		.in_user(s_axis_tuser),
		.q_valid(q_valid),
		.q_pop(q_pop),
		.q_data(q_data),
		.q_cls(q_cls)
	);

	tvs_back #(
		.MAX_RES(MAX_RES),
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.IDW(IDW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_cls(q_cls),
		.q_pop(q_pop),
		.issue_ok(issue_ok),
		.issue_sample(issue_sample),
		.resolution(resolution_q),
		.res_valid(res_valid),
		.res_data(res_data)
	);

	// Result credits: samples in flight plus results waiting.
	assign out_xfer = m_axis_tvalid && m_axis_tready;
	assign issue_ok = (occ_q < OCW'(OQ_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (issue_sample && !out_xfer) begin
			occ_q <= occ_q + 1'b1;
		end else if (out_xfer && !issue_sample) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	tvs_fifo #(
		.W(3 * OUT_W),
		.DEPTH(OQ_DEPTH)
	) u_oq (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.din(res_data),
		.full(oq_full),
		.pop(m_axis_tready),
		.dout(m_axis_tdata),
		.empty(oq_empty)
	);

	assign m_axis_tvalid = !oq_empty;

	// A finished result always finds room in the result queue.
	assert property (@(posedge clk) disable iff (!arst_n) res_valid |-> !oq_full)
		else $error("result queue overflow");

	// The credit count never exceeds the result queue depth.
	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= OCW'(OQ_DEPTH))
		else $error("result credit count out of range");

	// No result is offered while no sample is outstanding.
	assert property (@(posedge clk) disable iff (!arst_n) (occ_q == '0) |-> !m_axis_tvalid)
		else $error("result offered without an outstanding sample");

endmodule
